// File: design/rwhpb_pkg.sv
package rwhpb_pkg;

  localparam int FRAC_BITS = 16;
  localparam int POS_W = 32;
  localparam int DISP_W = 48;
  localparam int RAND_W = 16;
  localparam int DIR_BITS = 16;
  localparam int MAG_W = 32;
  localparam int SUM_W = 64;
  localparam int ROOT_W = 32;
  localparam int NUM_W = MAG_W + DIR_BITS;
  localparam int QUO_W = DIR_BITS + 2;
  localparam int LEN_W = POS_W + 2;
  localparam int STEP_W = LEN_W + 1;
  localparam int SUMP_W = POS_W + 4;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [RAND_W-1:0] HALF = RAND_W'(1) << (RAND_W - 1);
  localparam logic [POS_W-1:0] TENTH = POS_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [POS_W-1:0] BOX_RST = POS_W'(64'd100 << FRAC_BITS);
  localparam logic [POS_W-1:0] HOP_RST = POS_W'(64'd1 << FRAC_BITS);

  typedef enum logic [2:0] {
    REG_BOX_X = 3'd0,
    REG_BOX_Y = 3'd1,
    REG_BOX_Z = 3'd2,
    REG_HOP = 3'd3,
    REG_ZPER = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [RAND_W-1:0] rand_x;
    logic [RAND_W-1:0] rand_y;
    logic [RAND_W-1:0] rand_z;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;
    logic signed [DISP_W-1:0] disp_x;
    logic signed [DISP_W-1:0] disp_y;
    logic signed [DISP_W-1:0] disp_z;
    logic zero_vector;
  } out_item_t;

endpackage

// File: design/random_walk_hop_periodic_box_top.sv
// Channel  | direction | payload     | handshake
// in       | input     | in_item_t   | in_valid_i / in_stall_o
// out      | output    | out_item_t  | out_valid_o / out_stall_i
// cfg      | input     | 32-bit regs | APB, pready always high
// An item passes through normalize, squares, the bit-pair square root, then for each
// axis the radix-2 divider and the length multiply, and last the commit step. An
// all-zero sample vector skips the datapath and goes straight to the commit step. A
// result that waits on out_stall_i holds the sequencer in its commit step, and the
// input stays stalled until it commits.
// Reset is asynchronous and restores the box, hop and mode registers.
module random_walk_hop_periodic_box_top import rwhpb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_NORM  = 7'b0000010,
    S_SQR   = 7'b0000100,
    S_ROOT  = 7'b0001000,
    S_DINIT = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_MUL   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   upd_q, upd_d;
  logic [1:0] idx_q;
  logic [5:0] cnt_q;

  logic [POS_W-1:0] box_q [3];
  logic [POS_W-1:0] hop_q;
  logic             zper_q;

  logic [MAG_W-1:0] mag_q [3];
  logic             neg_q [3];
  logic             zero_q;
  logic [SUM_W-1:0] prod_q, sum_q, rv_q, rres_q, rbit_q;
  logic [NUM_W-1:0] num_q;
  logic [ROOT_W-1:0] rem_q;
  logic [QUO_W-1:0] quo_q;
  logic signed [STEP_W-1:0] d_q [3];
  logic [POS_W-1:0] cur_q [3];
  logic [DISP_W-1:0] walk_q [3];
  out_item_t out_q;
  logic      out_valid_q;

  logic in_acc, out_acc, cfg_wr, commit;
  logic [RAND_W-1:0] u [3];
  logic [RAND_W-1:0] in_mag [3];
  logic              in_neg [3];
  logic              in_zero;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_q && !out_stall_i;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign in_stall_o = (state_q != S_IDLE) || upd_q;
  assign commit = upd_q && !(out_valid_q && out_stall_i);

  // Center the incoming samples
  assign u[0] = in_data_i.rand_x;
  assign u[1] = in_data_i.rand_y;
  assign u[2] = in_data_i.rand_z;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_neg[i] = u[i] < HALF;
      in_mag[i] = in_neg[i] ? HALF - u[i] : u[i] - HALF;
    end
    in_zero = (in_mag[0] == '0) && (in_mag[1] == '0) && (in_mag[2] == '0);
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q[0] <= BOX_RST;
      box_q[1] <= BOX_RST;
      box_q[2] <= BOX_RST;
      hop_q <= HOP_RST;
      zper_q <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_BOX_X: box_q[0] <= pwdata[POS_W-1:0];
        REG_BOX_Y: box_q[1] <= pwdata[POS_W-1:0];
        REG_BOX_Z: box_q[2] <= pwdata[POS_W-1:0];
        REG_HOP:   hop_q <= pwdata[POS_W-1:0];
        REG_ZPER:  zper_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[4:2])
      REG_BOX_X: prdata = box_q[0];
      REG_BOX_Y: prdata = box_q[1];
      REG_BOX_Z: prdata = box_q[2];
      REG_HOP:   prdata = hop_q;
      REG_ZPER:  prdata = {{(DATA_W-1){1'b0}}, zper_q};
      default:   prdata = '0;
    endcase
  end

  // Datapath steps
  logic              norm_done;
  logic [1:0]        sqr_sel;
  logic [SUM_W-1:0]  rtrial;
  logic              rge;
  logic [ROOT_W-1:0] s_root;
  logic [ROOT_W:0]   dt;
  logic              dge;
  logic [POS_W+QUO_W-1:0] lprod;
  logic [LEN_W-1:0]  len;
  logic signed [STEP_W-1:0] dstep;

  assign norm_done = |(mag_q[0][MAG_W-1:MAG_W-2] | mag_q[1][MAG_W-1:MAG_W-2]
                       | mag_q[2][MAG_W-1:MAG_W-2]);
  assign sqr_sel = (cnt_q[1:0] == 2'd3) ? 2'd0 : cnt_q[1:0];
  assign rtrial = rres_q + rbit_q;
  assign rge = rv_q >= rtrial;
  assign s_root = rres_q[ROOT_W-1:0];
  assign dt = {rem_q, num_q[NUM_W-1]};
  assign dge = dt >= {1'b0, s_root};
  assign lprod = hop_q * quo_q + (POS_W+QUO_W)'(1 << (DIR_BITS - 1));
  assign len = lprod[DIR_BITS +: LEN_W];
  assign dstep = neg_q[idx_q] ? -$signed({1'b0, len}) : $signed({1'b0, len});

  // Sequencer
  always_comb begin
    state_d = state_q;
    upd_d = upd_q;
    unique case (state_q)
      S_IDLE: begin
        if (commit) upd_d = 1'b0;
        if (in_acc) begin
          if (in_zero) upd_d = 1'b1;
          else state_d = S_NORM;
        end
      end
      S_NORM:  if (norm_done) state_d = S_SQR;
      S_SQR:   if (cnt_q == 6'd3) state_d = S_ROOT;
      S_ROOT:  if (cnt_q == 6'd31) state_d = S_DINIT;
      S_DINIT: state_d = S_DIV;
      S_DIV:   if (cnt_q == 6'(NUM_W - 1)) state_d = S_MUL;
      S_MUL: begin
        if (idx_q == 2'd2) begin
          state_d = S_IDLE;
          upd_d = 1'b1;
        end else begin
          state_d = S_DINIT;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      upd_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      upd_q <= upd_d;
      if (commit) out_valid_q <= 1'b1;
      else if (out_acc) out_valid_q <= 1'b0;
    end
  end

  // Work registers: shift, square, root, divide, scale
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_q + 6'd1;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          for (int i = 0; i < 3; i++) begin
            mag_q[i] <= MAG_W'(in_mag[i]);
            neg_q[i] <= in_neg[i];
          end
          zero_q <= in_zero;
        end
      end
      S_NORM: begin
        cnt_q <= '0;
        sum_q <= '0;
        if (!norm_done) begin
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
        end
      end
      S_SQR: begin
        prod_q <= SUM_W'(mag_q[sqr_sel] * mag_q[sqr_sel]);
        if (cnt_q != 6'd0) sum_q <= sum_q + prod_q;
        if (cnt_q == 6'd3) begin
          rv_q <= sum_q + prod_q;
          rres_q <= '0;
          rbit_q <= SUM_W'(1) << (SUM_W - 2);
          cnt_q <= '0;
        end
      end
      S_ROOT: begin
        if (rge) begin
          rv_q <= rv_q - rtrial;
          rres_q <= (rres_q >> 1) + rbit_q;
        end else begin
          rres_q <= rres_q >> 1;
        end
        rbit_q <= rbit_q >> 2;
        idx_q <= '0;
      end
      S_DINIT: begin
        num_q <= {mag_q[idx_q], {DIR_BITS{1'b0}}} + NUM_W'(s_root >> 1);
        rem_q <= '0;
        quo_q <= '0;
        cnt_q <= '0;
      end
      S_DIV: begin
        rem_q <= dge ? ROOT_W'(dt - {1'b0, s_root}) : dt[ROOT_W-1:0];
        quo_q <= {quo_q[QUO_W-2:0], dge};
        num_q <= num_q << 1;
      end
      S_MUL: begin
        d_q[idx_q] <= dstep;
        idx_q <= idx_q + 2'd1;
      end
      default: ;
    endcase
  end

  // Apply the step to position and displacement
  logic signed [SUMP_W-1:0] p [3];
  logic signed [SUMP_W-1:0] bx [3];
  logic [POS_W-1:0]  ncur [3];
  logic [DISP_W-1:0] nwalk [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p[i] = $signed({4'b0, cur_q[i]}) + SUMP_W'(d_q[i]);
      bx[i] = $signed({4'b0, box_q[i]});
      if (p[i] >= bx[i]) ncur[i] = POS_W'(p[i] - bx[i]);
      else if (p[i][SUMP_W-1]) ncur[i] = POS_W'(p[i] + bx[i]);
      else ncur[i] = p[i][POS_W-1:0];
      nwalk[i] = walk_q[i] + DISP_W'(d_q[i]);
    end
    if (!zper_q) begin
      if (p[2] >= bx[2]) begin
        ncur[2] = (box_q[2] >= TENTH) ? box_q[2] - TENTH : '0;
        nwalk[2] = walk_q[2];
      end else if (p[2][SUMP_W-1]) begin
        ncur[2] = '0;
        nwalk[2] = walk_q[2];
      end else begin
        ncur[2] = p[2][POS_W-1:0];
      end
    end
    if (zero_q) begin
      for (int i = 0; i < 3; i++) begin
        ncur[i] = cur_q[i];
        nwalk[i] = walk_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        cur_q[i] <= '0;
        walk_q[i] <= '0;
      end
    end else if (commit) begin
      for (int i = 0; i < 3; i++) begin
        cur_q[i] <= ncur[i];
        walk_q[i] <= nwalk[i];
      end
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_q.pos_x <= ncur[0];
      out_q.pos_y <= ncur[1];
      out_q.pos_z <= ncur[2];
      out_q.disp_x <= $signed(nwalk[0]);
      out_q.disp_y <= $signed(nwalk[1]);
      out_q.disp_z <= $signed(nwalk[2]);
      out_q.zero_vector <= zero_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule

// File: design/rwhpb_checker.sv
module rwhpb_checker import rwhpb_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o,
  input logic      pready
);

  // Stall input after each transfer in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after transfer");

  // No result appears in the cycle right after a transfer in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result too early");

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Raise a result only while the input is held off by the commit step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without work");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind random_walk_hop_periodic_box_top rwhpb_checker u_rwhpb_checker (.*);

// File: dv/testbench.sv
module testbench import rwhpb_pkg::*; ();

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  in_item_t          in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  out_item_t         out_data_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  random_walk_hop_periodic_box_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  localparam int CYCLE_LIMIT = 2000000;

  // walker state mirrored from the block
  logic [POS_W-1:0]  box_x_q, box_y_q, box_z_q, hop_q;
  logic              zper_q;
  logic [POS_W-1:0]  pos_x_q, pos_y_q, pos_z_q;
  logic [DISP_W-1:0] walk_x_q, walk_y_q, walk_z_q;

  out_item_t pending_hops[$];
  int        errors;
  int        cycles;

  // directed rows; fixed flags mark rows with a hand-typed result
  typedef struct {
    in_item_t  stim;
    bit        fixed;
    out_item_t res;
  } hop_row_t;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint wrap_axis(logic [POS_W-1:0] cur, longint d,
                                       logic [POS_W-1:0] box);
    longint p;
    p = longint'({32'd0, cur}) + d;
    if (p >= longint'({32'd0, box})) p = p - longint'({32'd0, box});
    else if (p < 0) p = p + longint'({32'd0, box});
    return p;
  endfunction

  // advance the mirrored walker by one hop and return the expected transfer
  function automatic out_item_t predict_hop(in_item_t it);
    logic [63:0] mag[3];
    logic        neg[3];
    logic [15:0] u[3];
    longint      d[3];
    logic [63:0] m, s, r, len;
    longint      p;
    out_item_t   o;
    u[0] = it.rand_x; u[1] = it.rand_y; u[2] = it.rand_z;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = u[i] < HALF;
      mag[i] = neg[i] ? 64'(HALF - u[i]) : 64'(u[i] - HALF);
      if (mag[i] > m) m = mag[i];
    end
    o.zero_vector = (m == 0);
    if (m != 0) begin
      while (m < (64'd1 << 30)) begin
        m = m << 1;
        for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      end
      s = root64(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
      if (s == 0) s = 1;
      for (int i = 0; i < 3; i++) begin
        r = ((mag[i] << DIR_BITS) + (s >> 1)) / s;
        len = ({32'd0, hop_q} * r + (64'd1 << (DIR_BITS - 1))) >> DIR_BITS;
        d[i] = neg[i] ? -longint'(len) : longint'(len);
      end
      pos_x_q = POS_W'(wrap_axis(pos_x_q, d[0], box_x_q));
      pos_y_q = POS_W'(wrap_axis(pos_y_q, d[1], box_y_q));
      walk_x_q = walk_x_q + DISP_W'(d[0]);
      walk_y_q = walk_y_q + DISP_W'(d[1]);
      if (zper_q) begin
        pos_z_q = POS_W'(wrap_axis(pos_z_q, d[2], box_z_q));
        walk_z_q = walk_z_q + DISP_W'(d[2]);
      end else begin
        p = longint'({32'd0, pos_z_q}) + d[2];
        if (p >= longint'({32'd0, box_z_q}))
          pos_z_q = (box_z_q >= TENTH) ? box_z_q - TENTH : '0;
        else if (p < 0) pos_z_q = '0;
        else begin
          pos_z_q = POS_W'(p);
          walk_z_q = walk_z_q + DISP_W'(d[2]);
        end
      end
    end
    o.pos_x = pos_x_q; o.pos_y = pos_y_q; o.pos_z = pos_z_q;
    o.disp_x = walk_x_q; o.disp_y = walk_y_q; o.disp_z = walk_z_q;
    return o;
  endfunction

  // drop valid for a random gap; no gap keeps transfers back to back
  task automatic idle_cycles(int hi);
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, hi) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n != 0) in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // one APB write, setup then access, then idle
  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * int'(idx)); pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_BOX_X: box_x_q = val;
      REG_BOX_Y: box_y_q = val;
      REG_BOX_Z: box_z_q = val;
      REG_HOP:   hop_q = val;
      REG_ZPER:  zper_q = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_hop(in_item_t it);
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_hops.push_back(predict_hop(it));
  endtask

  task automatic drain_hops();
    in_valid_i <= 1'b0;
    while (pending_hops.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // random samples: mostly uniform, sometimes pinned to the center or extremes
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return HALF;
      1: return 16'h0000;
      2: return 16'hffff;
      3: return HALF + 16'($urandom_range(0, 4)) - 16'd2;
      default: return 16'($urandom);
    endcase
  endfunction

  // receive side: random stall, compare each transfer
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_hops.size() == 0) begin
          $display("%0t unexpected transfer %h", $time, out_data_o);
          errors++;
        end else begin
          want = pending_hops.pop_front();
          if (out_data_o.pos_x !== want.pos_x)
            $display("%0t pos_x exp %h got %h", $time, want.pos_x, out_data_o.pos_x);
          if (out_data_o.pos_y !== want.pos_y)
            $display("%0t pos_y exp %h got %h", $time, want.pos_y, out_data_o.pos_y);
          if (out_data_o.pos_z !== want.pos_z)
            $display("%0t pos_z exp %h got %h", $time, want.pos_z, out_data_o.pos_z);
          if (out_data_o.disp_x !== want.disp_x)
            $display("%0t disp_x exp %h got %h", $time, want.disp_x, out_data_o.disp_x);
          if (out_data_o.disp_y !== want.disp_y)
            $display("%0t disp_y exp %h got %h", $time, want.disp_y, out_data_o.disp_y);
          if (out_data_o.disp_z !== want.disp_z)
            $display("%0t disp_z exp %h got %h", $time, want.disp_z, out_data_o.disp_z);
          if (out_data_o.zero_vector !== want.zero_vector)
            $display("%0t zero_vector exp %b got %b", $time, want.zero_vector,
                     out_data_o.zero_vector);
          if (out_data_o !== want) errors++;
        end
      end
      if ($urandom_range(0, 19) == 0) out_stall_i <= 1'b1;
      else if ($urandom_range(0, 30) == 0) out_stall_i <= 1'b0;
      else if (out_stall_i) out_stall_i <= ($urandom_range(0, 4) != 0);
    end
  end

  initial begin
    hop_row_t    rows[$];
    hop_row_t    row;
    out_item_t   zero_res;
    in_item_t    it;
    logic [31:0] v;
    clk_i = 1'b0; rst_ni = 1'b0;
    in_valid_i = 1'b0; in_data_i = '0; out_stall_i = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    errors = 0; cycles = 0;
    box_x_q = BOX_RST; box_y_q = BOX_RST; box_z_q = BOX_RST;
    hop_q = HOP_RST; zper_q = 1'b1;
    pos_x_q = '0; pos_y_q = '0; pos_z_q = '0;
    walk_x_q = '0; walk_y_q = '0; walk_z_q = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero vector right after reset: all zeros and the flag
    zero_res = '0; zero_res.zero_vector = 1'b1;
    row.stim = '{HALF, HALF, HALF}; row.fixed = 1; row.res = zero_res; rows.push_back(row);
    row.fixed = 0;
    row.stim = '{16'h0000, HALF, HALF}; rows.push_back(row);
    row.stim = '{16'hffff, HALF, HALF}; rows.push_back(row);
    row.stim = '{HALF, 16'h0000, HALF}; rows.push_back(row);
    row.stim = '{HALF, 16'hffff, HALF}; rows.push_back(row);
    row.stim = '{HALF, HALF, 16'h0000}; rows.push_back(row);
    row.stim = '{HALF, HALF, 16'hffff}; rows.push_back(row);
    row.stim = '{16'h0000, 16'h0000, 16'h0000}; rows.push_back(row);
    row.stim = '{16'hffff, 16'hffff, 16'hffff}; rows.push_back(row);
    row.stim = '{16'h8001, 16'h7fff, 16'h8000}; rows.push_back(row);
    row.stim = '{16'h5555, 16'haaaa, 16'h1234}; rows.push_back(row);
    for (int i = 0; i < 10; i++) begin
      row.stim = '{16'h0000, 16'h0000, 16'h0000}; rows.push_back(row);
    end
    foreach (rows[i]) begin
      idle_cycles(40);
      send_hop(rows[i].stim);
      if (rows[i].fixed) void'(pending_hops.pop_back());
      if (rows[i].fixed) pending_hops.push_back(rows[i].res);
    end
    drain_hops();

    // phases: hop longer than box, tiny z box with clamp, one-LSB box, max/zero hop, random
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_BOX_X, 32'h0003_0000); write_reg(REG_BOX_Y, 32'h0000_8000);
          write_reg(REG_BOX_Z, 32'h0000_1000); write_reg(REG_HOP, 32'h0002_0000);
          write_reg(REG_ZPER, 32'd0);
        end
        1: begin
          write_reg(REG_BOX_Z, 32'h0000_0001); write_reg(REG_HOP, 32'hffff_ffff);
        end
        2: begin
          write_reg(REG_BOX_X, 32'hffff_ffff); write_reg(REG_BOX_Y, 32'd1);
          write_reg(REG_BOX_Z, 32'hffff_ffff); write_reg(REG_HOP, 32'd0);
          write_reg(REG_ZPER, 32'd1);
        end
        3: begin
          write_reg(REG_HOP, 32'h7fff_ffff); write_reg(REG_ZPER, 32'd0);
        end
        default: begin
          v = $urandom; write_reg(REG_BOX_X, v | 32'd1);
          v = $urandom; write_reg(REG_BOX_Y, v | 32'd1);
          v = $urandom_range(1, 32'h00ff_ffff); write_reg(REG_BOX_Z, v);
          write_reg(REG_HOP, $urandom_range(0, 32'h0008_0000));
          write_reg(REG_ZPER, $urandom_range(0, 1));
        end
      endcase
      for (int n = 0; n < 90; n++) begin
        it.rand_x = pick_sample(); it.rand_y = pick_sample(); it.rand_z = pick_sample();
        idle_cycles(60);
        send_hop(it);
      end
      drain_hops();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
